[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/rcog_pkg.sv]
package rcog_pkg;

    localparam int ANGLE_FRAC_BITS = 22;
    localparam int CORDIC_STEPS    = 24;
    localparam int AW              = 36;
    localparam int CW              = 64;

    localparam logic signed [AW-1:0] FULL_TURN = AW'(360) <<< ANGLE_FRAC_BITS;
    localparam logic signed [AW-1:0] HALF_TURN = AW'(180) <<< ANGLE_FRAC_BITS;
    localparam logic signed [AW-1:0] QTR_TURN  = AW'(90) <<< ANGLE_FRAC_BITS;
    localparam logic [29:0] KGAIN_Q30 = 30'd652032874;

    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_RESTART = 2'd1,
        REQ_PAUSE   = 2'd2,
        REQ_RESUME  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        REG_CENTER_X  = 3'd0,
        REG_CENTER_Y  = 3'd1,
        REG_RADIUS    = 3'd2,
        REG_MIN_RATE  = 3'd3,
        REG_MAX_RATE  = 3'd4,
        REG_ACCEL     = 3'd5,
        REG_START     = 3'd6,
        REG_CLOCKWISE = 3'd7
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_RATE,
        ST_CLAMP,
        ST_MUL_ANG,
        ST_WRAP,
        ST_FOLD,
        ST_GAIN,
        ST_CORDIC,
        ST_OUT_X,
        ST_OUT_Y,
        ST_DONE
    } state_t;

    function automatic logic [34:0] atan_lut(input logic [4:0] i);
        logic [34:0] r;
        begin
            case (i)
                5'd0:  r = 35'd754974720;
                5'd1:  r = 35'd445687602;
                5'd2:  r = 35'd235489088;
                5'd3:  r = 35'd119537938;
                5'd4:  r = 35'd60000934;
                5'd5:  r = 35'd30029717;
                5'd6:  r = 35'd15018523;
                5'd7:  r = 35'd7509720;
                5'd8:  r = 35'd3754917;
                5'd9:  r = 35'd1877466;
                5'd10: r = 35'd938734;
                5'd11: r = 35'd469367;
                5'd12: r = 35'd234684;
                5'd13: r = 35'd117342;
                5'd14: r = 35'd58671;
                5'd15: r = 35'd29335;
                5'd16: r = 35'd14668;
                5'd17: r = 35'd7334;
                5'd18: r = 35'd3667;
                5'd19: r = 35'd1833;
                5'd20: r = 35'd917;
                5'd21: r = 35'd458;
                5'd22: r = 35'd229;
                5'd23: r = 35'd115;
                5'd24: r = 35'd57;
                5'd25: r = 35'd29;
                5'd26: r = 35'd14;
                5'd27: r = 35'd7;
                5'd28: r = 35'd4;
                5'd29: r = 35'd2;
                5'd30: r = 35'd1;
                default: r = 35'd0;
            endcase
            return r;
        end
    endfunction

endpackage

[hdl/ramped_circle_orbit_generator.sv]
// Channel   Dir  Payload (low bit first)                          Handshake
// s_axis    in   tuser: req_type[1:0]; tdata: time_stamp[31:0]    tvalid/tready
// m_axis    out  tdata: pos_x, pos_y, angle_now, is_running       tvalid/tready
// cfg       in   cfg_wr, cfg_addr[2:0], cfg_wdata[31:0]           write enable
// Tick that moves: serial rate multiply and clamp (skipped without acceleration), serial
// angle multiply, mod reduction, fold, serial gain multiply, CORDIC, X and Y output states.
// Restart: fold, gain multiply, CORDIC and output states; other requests go straight to done.
// s_axis_tready is high only in idle; a result waits in the output register while the
// next request runs, and that request's result waits in the done state.
// Reset (rst_n low, asynchronous) clears all motion state.
module ramped_circle_orbit_generator
    import rcog_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [1:0]   s_axis_tuser,   // req_type[1:0]
    input  logic [31:0]  s_axis_tdata,   // time_stamp[31:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,   // pos_x, pos_y, angle_now, is_running
    input  logic         cfg_wr,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata
);

`include "assert_macros.svh"

    logic signed [31:0] center_x_reg, center_y_reg, accel_reg, start_reg;
    logic [23:0]        radius_reg;
    logic [31:0]        min_reg, max_reg;
    logic               cw_reg;

    logic [31:0]        prev_time_reg;
    logic               first_reg, running_reg;
    logic signed [CW-1:0] rate_reg;
    logic signed [AW-1:0] angle_reg;
    logic signed [31:0] cur_x_reg, cur_y_reg;

    state_t             state_reg, state_next;
    logic [31:0]        dt_reg;
    logic [5:0]         cnt_reg;
    logic [CW-1:0]      acc_reg;
    logic [CW-1:0]      mcand_reg;
    logic [31:0]        mplier_reg;
    logic               neg_reg;
    logic signed [47:0] cx_reg, cy_reg;
    logic signed [AW:0] cz_reg;
    logic [103:0]       out_reg;

    logic               s_fire;
    logic [1:0]         req;
    logic [31:0]        now;

    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign req    = s_axis_tuser;
    assign now    = s_axis_tdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_reg   <= '0;
            min_reg      <= '0;
            max_reg      <= '0;
            accel_reg    <= '0;
            start_reg    <= '0;
            cw_reg       <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(cfg_addr))
                REG_CENTER_X:  center_x_reg <= cfg_wdata;
                REG_CENTER_Y:  center_y_reg <= cfg_wdata;
                REG_RADIUS:    radius_reg   <= cfg_wdata[23:0];
                REG_MIN_RATE:  min_reg      <= cfg_wdata;
                REG_MAX_RATE:  max_reg      <= cfg_wdata;
                REG_ACCEL:     accel_reg    <= cfg_wdata;
                REG_START:     start_reg    <= cfg_wdata;
                REG_CLOCKWISE: cw_reg       <= cfg_wdata[0];
                default:       ;
            endcase
        end
    end

    // wrap helpers: value in (-2F, 2F] range after one subtract suffices
    logic signed [AW-1:0] start_ext, start_wrapped;
    assign start_ext = AW'(start_reg);
    always_comb
    begin
        start_wrapped = start_ext;
        if (start_ext > FULL_TURN)
        begin
            start_wrapped = start_ext - FULL_TURN;
            if (start_wrapped > FULL_TURN)
                start_wrapped = start_wrapped - FULL_TURN;
        end
        else if (start_ext < -FULL_TURN)
        begin
            start_wrapped = start_ext + FULL_TURN;
            if (start_wrapped < -FULL_TURN)
                start_wrapped = start_wrapped + FULL_TURN;
        end
    end

    // serial multiply step: one multiplier bit per cycle
    logic [CW-1:0] acc_step;
    assign acc_step = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;

    // rate clamp
    logic signed [CW-1:0] rate_sum, rate_clamped;
    assign rate_sum = rate_reg + $signed(acc_reg);
    always_comb
    begin
        rate_clamped = rate_sum;
        if (accel_reg > 0 && rate_sum > $signed(CW'(max_reg)))
            rate_clamped = CW'(max_reg);
        else if (accel_reg < 0 && rate_sum < $signed(CW'(min_reg)))
            rate_clamped = CW'(min_reg);
    end

    // angle wrap by reduction: product reduced mod F one shift of F per cycle
    logic [CW-1:0] red_sub;
    logic [CW-1:0] f_shift;
    assign f_shift = CW'(FULL_TURN) << cnt_reg;
    assign red_sub = acc_reg - f_shift;

    logic signed [AW:0] ang_try;
    logic signed [AW:0] dm;
    logic signed [AW:0] ang_base, ang_u;
    always_comb
    begin
        if (acc_reg >= CW'(FULL_TURN))
            dm = (AW+1)'(acc_reg - CW'(FULL_TURN));
        else
            dm = (AW+1)'(acc_reg);
        if (cw_reg)
            ang_base = (AW+1)'(FULL_TURN) + (AW+1)'(angle_reg);
        else
            ang_base = (AW+1)'(FULL_TURN) - (AW+1)'(angle_reg);
        if (ang_base >= (AW+1)'(FULL_TURN)) ang_base = ang_base - (AW+1)'(FULL_TURN);
        if (ang_base >= (AW+1)'(FULL_TURN)) ang_base = ang_base - (AW+1)'(FULL_TURN);
        ang_u = ang_base + dm;
        if (ang_u == 0)
            ang_u = (AW+1)'(FULL_TURN);
        else if (ang_u > (AW+1)'(FULL_TURN))
            ang_u = ang_u - (AW+1)'(FULL_TURN);
        ang_try = cw_reg ? ang_u : -ang_u;
    end
    logic small_move;
    always_comb
    begin
        if (cw_reg)
            small_move = mcand_reg <= CW'(FULL_TURN - angle_reg);
        else
            small_move = mcand_reg <= CW'(angle_reg + FULL_TURN);
    end

    // CORDIC step
    logic signed [47:0] dx, dy;
    logic [34:0]        at;
    assign dx = cy_reg >>> cnt_reg[4:0];
    assign dy = cx_reg >>> cnt_reg[4:0];
    assign at = atan_lut(cnt_reg[4:0]);

    logic signed [AW-1:0] th_fold;
    logic                 neg_fold;
    always_comb
    begin
        th_fold = angle_reg;
        neg_fold = 1'b0;
        if (th_fold > HALF_TURN)   th_fold = th_fold - FULL_TURN;
        if (th_fold <= -HALF_TURN) th_fold = th_fold + FULL_TURN;
        if (th_fold > QTR_TURN)
        begin
            th_fold = th_fold - HALF_TURN;
            neg_fold = 1'b1;
        end
        else if (th_fold < -QTR_TURN)
        begin
            th_fold = th_fold + HALF_TURN;
            neg_fold = 1'b1;
        end
    end

    logic signed [48:0] pos_sum;
    logic signed [31:0] pos_sat;
    logic signed [47:0] rot_v;
    always_comb
    begin
        rot_v = (state_reg == ST_OUT_X) ? cy_reg : cx_reg;
        if (neg_reg) rot_v = -rot_v;
        pos_sum = 49'((rot_v + 48'sd32768) >>> 16)
                + 49'((state_reg == ST_OUT_X) ? center_x_reg : center_y_reg);
        if (pos_sum > 49'sd2147483647)       pos_sat = 32'sh7fffffff;
        else if (pos_sum < -49'sd2147483648) pos_sat = 32'sh80000000;
        else                                 pos_sat = pos_sum[31:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (s_fire)
                begin
                    if (req == REQ_RESTART) state_next = ST_FOLD;
                    else if (req == REQ_TICK && !first_reg && running_reg)
                        state_next = (accel_reg == 0) ? ST_MUL_ANG : ST_MUL_RATE;
                    else state_next = ST_DONE;
                end
            ST_MUL_RATE: if (cnt_reg == 6'd31) state_next = ST_CLAMP;
            ST_CLAMP:    state_next = ST_MUL_ANG;
            ST_MUL_ANG:  if (cnt_reg == 6'd31) state_next = ST_WRAP;
            ST_WRAP:     if (cnt_reg == 6'd0) state_next = ST_FOLD;
            ST_FOLD:     state_next = ST_GAIN;
            ST_GAIN:     if (cnt_reg == 6'd29) state_next = ST_CORDIC;
            ST_CORDIC:   if (cnt_reg == 6'(CORDIC_STEPS - 1)) state_next = ST_OUT_X;
            ST_OUT_X:    state_next = ST_OUT_Y;
            ST_OUT_Y:    state_next = ST_DONE;
            ST_DONE:     if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
    end

    logic m_valid_reg;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prev_time_reg <= '0;
            first_reg     <= 1'b1;
            running_reg   <= 1'b0;
            rate_reg      <= '0;
            angle_reg     <= '0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            m_valid_reg   <= 1'b0;
            cnt_reg       <= '0;
            dt_reg        <= '0;
            acc_reg       <= '0;
            mcand_reg     <= '0;
            mplier_reg    <= '0;
            neg_reg       <= 1'b0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            cz_reg        <= '0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && (!m_valid_reg || m_axis_tready))
            begin
                m_valid_reg <= 1'b1;
                out_reg <= {7'd0, running_reg, angle_reg[31:0], cur_y_reg, cur_x_reg};
            end
            else if (m_valid_reg && m_axis_tready)
                m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                    if (s_fire)
                    begin
                        cnt_reg <= '0;
                        acc_reg <= '0;
                        case (req_t'(req))
                            REQ_TICK:
                            begin
                                dt_reg        <= now - prev_time_reg;
                                prev_time_reg <= now;
                                if (first_reg) first_reg <= 1'b0;
                                mplier_reg <= now - prev_time_reg;
                                if (accel_reg == 0)
                                    mcand_reg <= rate_reg;
                                else
                                    mcand_reg <= CW'(accel_reg);
                            end
                            REQ_RESTART:
                            begin
                                running_reg <= 1'b0;
                                rate_reg <= (accel_reg > 0) ? CW'(min_reg) : CW'(max_reg);
                                angle_reg <= start_wrapped;
                            end
                            REQ_PAUSE:  running_reg <= 1'b0;
                            REQ_RESUME: running_reg <= 1'b1;
                            default: ;
                        endcase
                    end
                ST_MUL_RATE:
                begin
                    acc_reg    <= acc_step;
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                    if (cnt_reg == 6'd31) cnt_reg <= '0;
                    else                  cnt_reg <= cnt_reg + 6'd1;
                end
                ST_CLAMP:
                begin
                    rate_reg   <= rate_clamped;
                    mcand_reg  <= rate_clamped;
                    mplier_reg <= dt_reg;
                    acc_reg    <= '0;
                end
                ST_MUL_ANG:
                begin
                    acc_reg    <= acc_step;
                    mplier_reg <= mplier_reg >> 1;
                    if (cnt_reg == 6'd31)
                    begin
                        // hold the product for the in-range test
                        mcand_reg <= acc_step;
                        cnt_reg   <= 6'd33;
                    end
                    else
                    begin
                        mcand_reg <= mcand_reg << 1;
                        cnt_reg   <= cnt_reg + 6'd1;
                    end
                end
                ST_WRAP:
                begin
                    if (cnt_reg != 6'd0)
                    begin
                        if (acc_reg >= f_shift) acc_reg <= red_sub;
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                    else
                        angle_reg <= small_move
                            ? (cw_reg ? angle_reg + AW'(mcand_reg) : angle_reg - AW'(mcand_reg))
                            : ang_try[AW-1:0];
                end
                ST_FOLD:
                begin
                    acc_reg    <= '0;
                    mcand_reg  <= CW'(radius_reg);
                    mplier_reg <= 32'(KGAIN_Q30);
                    cnt_reg    <= '0;
                end
                ST_GAIN:
                begin
                    acc_reg    <= acc_step;
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                    if (cnt_reg == 6'd29)
                    begin
                        cnt_reg <= '0;
                        cx_reg  <= 48'((acc_step + 64'd8192) >> 14);
                        cy_reg  <= '0;
                        cz_reg  <= (AW+1)'(th_fold) <<< (24 - ANGLE_FRAC_BITS);
                        neg_reg <= neg_fold;
                    end
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                end
                ST_CORDIC:
                begin
                    if (cz_reg >= 0)
                    begin
                        cx_reg <= cx_reg - dx;
                        cy_reg <= cy_reg + dy;
                        cz_reg <= cz_reg - $signed((AW+1)'(at));
                    end
                    else
                    begin
                        cx_reg <= cx_reg + dx;
                        cy_reg <= cy_reg - dy;
                        cz_reg <= cz_reg + $signed((AW+1)'(at));
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                end
                ST_OUT_X: cur_x_reg <= pos_sat;
                ST_OUT_Y: cur_y_reg <= pos_sat;
                default: ;
            endcase
        end
    end

    `CHK_IMPL(a_ready_idle, clk, rst_n, s_axis_tready, state_reg == ST_IDLE,
        "ready outside idle")
    `CHK_NEXT(a_fire_busy, clk, rst_n, s_fire, !s_axis_tready,
        "second transfer accepted while busy")
    `CHK_IMPL(a_angle_range, clk, rst_n, state_reg == ST_DONE,
        angle_reg <= FULL_TURN && angle_reg >= -FULL_TURN, "angle out of range")

endmodule
